// ----- hw/rtl/acpt_pkg.sv -----
// ----------------------------------------------------------------------------
// acpt_pkg
// Shared constants, types and codes for the aabb pair contact tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package acpt_pkg;

  localparam int unsigned LAYER_COUNT   = 8;
  localparam int unsigned LAYER_W       = 3;
  localparam int unsigned MAX_COLLIDERS = 64;
  localparam int unsigned ID_W          = 6;
  localparam int unsigned PAIR_W        = 2 * ID_W;
  localparam int unsigned PAIR_DEPTH    = MAX_COLLIDERS * MAX_COLLIDERS;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned CFG_W         = 64;
  localparam int unsigned IN_DATA_W     = 152;
  localparam int unsigned OUT_DATA_W    = 8;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } back_state_e;

  // one classified item between the front and the back
  typedef struct packed {
    logic              active;
    logic              overlap;
    logic              dead;
    logic [PAIR_W-1:0] idx;
  } pair_job_t;

endpackage : acpt_pkg

`default_nettype wire

// ----- hw/rtl/aabb_pair_contact_tracker.sv -----
// ----------------------------------------------------------------------------
// aabb_pair_contact_tracker
// Box overlap test per collider pair with enter / stay / exit tracking.
// ----------------------------------------------------------------------------
// flow: accepted items pass the two-entry queue, then the registered touching-bit read, then
//   the decision, which writes the bit back and loads the output register once the output is free
// the back takes a new item only after the read-modify-write of the last item's touching bit
// reset: layer enable cleared; then a clearing pass zeroes all
//   touching bits with s_axis_tready_o low (config writes still taken)
`default_nettype none

module aabb_pair_contact_tracker import acpt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // layer_pair, first_id, second_id, first_center_x, first_center_y,
  // first_width, first_height, second_center_x, second_center_y,
  // second_width, second_height, either_dead
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // contact_event
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  pair_job_t front_job, queue_job;
  logic      push, pop, queue_full, queue_valid, clearing;

  acpt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .queue_full_i    (queue_full),
    .clearing_i      (clearing),
    .push_o          (push),
    .job_o           (front_job)
  );

  acpt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .job_o   (queue_job)
  );

  acpt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (queue_valid),
    .job_i           (queue_job),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule : aabb_pair_contact_tracker

`default_nettype wire

// ----- hw/rtl/acpt_ram.sv -----
// ----------------------------------------------------------------------------
// acpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acpt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : acpt_ram

`default_nettype wire

// ----- hw/rtl/acpt_front.sv -----
// ----------------------------------------------------------------------------
// acpt_front
// Accepts pair items, checks layer enable and ids, and tests box overlap.
// ----------------------------------------------------------------------------
`default_nettype none

module acpt_front import acpt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input  wire logic                 queue_full_i,
  input  wire logic                 clearing_i,
  output logic                      push_o,
  output pair_job_t                 job_o
);

  logic [CFG_W-1:0] enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  logic [LAYER_W-1:0] layer_a, layer_b, layer_lo, layer_hi;
  logic [ID_W-1:0]    id1, id2;
  logic [COORD_W-1:0] c1x, c1y, w1, h1, c2x, c2y, w2, h2;
  logic               dead;
  logic [5:0]         enable_bit;
  logic               ovl_x, ovl_y;

  assign layer_a = s_axis_tdata_i[5:3];
  assign layer_b = s_axis_tdata_i[2:0];
  assign id1     = s_axis_tdata_i[11:6];
  assign id2     = s_axis_tdata_i[17:12];
  assign c1x     = s_axis_tdata_i[33:18];
  assign c1y     = s_axis_tdata_i[49:34];
  assign w1      = s_axis_tdata_i[65:50];
  assign h1      = s_axis_tdata_i[81:66];
  assign c2x     = s_axis_tdata_i[97:82];
  assign c2y     = s_axis_tdata_i[113:98];
  assign w2      = s_axis_tdata_i[129:114];
  assign h2      = s_axis_tdata_i[145:130];
  assign dead    = s_axis_tdata_i[146];

  // (a,b) and (b,a) share one enable bit
  assign layer_lo   = (layer_a < layer_b) ? layer_a : layer_b;
  assign layer_hi   = (layer_a < layer_b) ? layer_b : layer_a;
  assign enable_bit = {layer_lo, layer_hi};

  // strict overlap on one axis: 2*|c1-c2| < s1+s2
  function automatic logic axis_hit(input logic [COORD_W-1:0] ca,
                                    input logic [COORD_W-1:0] cb,
                                    input logic [COORD_W-1:0] sa,
                                    input logic [COORD_W-1:0] sb);
    logic signed [COORD_W:0] diff;
    logic        [COORD_W:0] mag;
    logic        [COORD_W+1:0] twice;
    logic        [COORD_W+1:0] sum;
    diff  = $signed({ca[COORD_W-1], ca}) - $signed({cb[COORD_W-1], cb});
    mag   = diff[COORD_W] ? (~diff + 1'b1) : diff;
    twice = {mag, 1'b0};
    sum   = {2'b00, sa} + {2'b00, sb};
    return twice < sum;
  endfunction

  assign ovl_x = axis_hit(c1x, c2x, w1, w2);
  assign ovl_y = axis_hit(c1y, c2y, h1, h2);

  assign s_axis_tready_o = !queue_full_i && !clearing_i;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o;

  assign job_o.active  = enable_q[enable_bit] && (id1 != id2);
  assign job_o.overlap = ovl_x && ovl_y;
  assign job_o.dead    = dead;
  assign job_o.idx     = {id1, id2};

endmodule : acpt_front

`default_nettype wire

// ----- hw/rtl/acpt_fifo.sv -----
// ----------------------------------------------------------------------------
// acpt_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module acpt_fifo import acpt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire pair_job_t job_i,
  input  wire logic      pop_i,
  output logic           full_o,
  output logic           valid_o,
  output pair_job_t      job_o
);

  pair_job_t  entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule : acpt_fifo

`default_nettype wire

// ----- hw/rtl/acpt_back.sv -----
// ----------------------------------------------------------------------------
// acpt_back
// Touching-bit read-modify-write, event decision and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acpt_back import acpt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  job_valid_i,
  input  wire pair_job_t             job_i,
  output logic                       pop_o,
  output logic                       clearing_o,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  back_state_e    state_q, state_d;
  logic [PAIR_W-1:0] clr_q, clr_d;
  pair_job_t      job_q, job_d;
  logic           out_valid_q, out_valid_d;
  contact_event_e out_ev_q, out_ev_d;

  logic              ram_we, ram_re, ram_wdata, touching;
  logic [PAIR_W-1:0] ram_waddr;
  logic              out_free;
  contact_event_e    ev;
  logic              ev_write, ev_wbit;

  acpt_ram #(
    .WIDTH (1),
    .DEPTH (PAIR_DEPTH)
  ) u_touch_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (job_i.idx),
    .rdata_o (touching)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    ev       = EV_NONE;
    ev_write = 1'b0;
    ev_wbit  = 1'b0;
    if (job_q.active) begin
      if (job_q.overlap) begin
        if (touching) begin
          ev       = job_q.dead ? EV_EXIT : EV_STAY;
          ev_write = job_q.dead;
        end else if (!job_q.dead) begin
          ev       = EV_ENTER;
          ev_write = 1'b1;
          ev_wbit  = 1'b1;
        end
      end else if (touching) begin
        ev       = EV_EXIT;
        ev_write = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    job_d       = job_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_ev_d    = out_ev_q;
    ram_we      = 1'b0;
    ram_waddr   = job_q.idx;
    ram_wdata   = ev_wbit;
    ram_re      = 1'b0;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == PAIR_W'(PAIR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          ram_re  = 1'b1;
          job_d   = job_i;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          ram_we      = ev_write;
          out_valid_d = 1'b1;
          out_ev_d    = ev;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    out_ev_q <= out_ev_d;
  end

  assign clearing_o      = (state_q == ST_CLEAR);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - 2){1'b0}}, out_ev_q};

endmodule : acpt_back

`default_nettype wire
